FILE: rtl/xmodem_block_receiver_macros.svh
// Assertion helpers used by the top-level receiver RTL.
`ifndef XMODEM_BLOCK_RECEIVER_MACROS_SVH
`define XMODEM_BLOCK_RECEIVER_MACROS_SVH

`define XMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define XMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/xmr_pkg.sv
package xmr_pkg;

  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_STX  = 8'h02;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_ACK  = 8'h06;
  localparam logic [7:0] B_NAK  = 8'h15;
  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_POLL = 8'h43;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [1:0] REG_RETRY    = 2'd0;
  localparam logic [1:0] REG_POLL     = 2'd1;
  localparam logic [1:0] REG_FALLBACK = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  localparam logic [2:0] VERD_NONE  = 3'd0;
  localparam logic [2:0] VERD_ACCEPT = 3'd1;
  localparam logic [2:0] VERD_DUP   = 3'd2;
  localparam logic [2:0] VERD_RETRY = 3'd3;
  localparam logic [2:0] VERD_ABORT = 3'd4;

  localparam logic [2:0] STAT_ACTIVE = 3'd0;
  localparam logic [2:0] STAT_DONE   = 3'd1;
  localparam logic [2:0] STAT_CANCEL = 3'd2;
  localparam logic [2:0] STAT_ERROR  = 3'd3;
  localparam logic [2:0] STAT_CAP    = 3'd4;

  localparam int unsigned LONG_BLOCK_BYTES  = 1024;
  localparam int unsigned SHORT_BLOCK_BYTES = 128;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_POLL  = 4'b0010,
    PH_FRAME = 4'b0100,
    PH_NEXT  = 4'b1000
  } phase_e;

  // Kind of response sequence the back end has to play out.
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SINGLE  = 3'd1,
    ACT_ACK2    = 3'd2,
    ACT_CAN3    = 3'd3,
    ACT_SILENT  = 3'd4
  } act_e;

  typedef struct packed {
    act_e       act;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic [2:0] status;
    logic [23:0] count;
  } cmd_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [2:0] frame_verdict;
    logic [2:0] session_status;
    logic [23:0] delivered_count;
    logic       last;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/xmr_if.sv
interface xmr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;
  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

interface xmr_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_verdict;
  logic [2:0]  session_status;
  logic [23:0] delivered_count;
  logic        last;
  modport source (output valid, tx_valid, tx_byte, payload_valid, payload_byte,
                  frame_verdict, session_status, delivered_count, last, input ready);
  modport sink (input valid, tx_valid, tx_byte, payload_valid, payload_byte,
                frame_verdict, session_status, delivered_count, last, output ready);
endinterface

interface xmr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/xmr_front.sv
module xmr_front #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [5:0]        retry_limit_i,
  input  logic [7:0]        poll_limit_i,
  input  logic [7:0]        fallback_poll_i,
  input  logic [23:0]       capacity_i,
  output xmr_pkg::cmd_t     cmd_o
);

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  xmr_pkg::phase_e phase_q, phase_d;
  logic        crc_mode_q, crc_mode_d;
  logic [7:0]  poll_q, poll_d;
  logic [7:0]  exp_q, exp_d;
  logic [5:0]  retry_q, retry_d;
  logic [10:0] idx_q, idx_d;
  logic        long_q, long_d;
  logic [7:0]  blk_q, blk_d, cmp_q, cmp_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  sum_q, sum_d, chk_q, chk_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;

  xmr_pkg::cmd_t c;
  logic [10:0] nlen;
  logic [COUNT_BITS:0] acc_sum;
  logic good, chk_ok, at_end;
  logic [6:0] nr;
  logic crc_eff;

  always_comb begin
    phase_d = phase_q; crc_mode_d = crc_mode_q; poll_d = poll_q; exp_d = exp_q;
    retry_d = retry_q; idx_d = idx_q; long_d = long_q; blk_d = blk_q; cmp_d = cmp_q;
    crc_d = crc_q; sum_d = sum_q; chk_d = chk_q; acc_d = acc_q;
    c = '0;
    c.act = xmr_pkg::ACT_NONE;
    nlen = long_q ? 11'(xmr_pkg::LONG_BLOCK_BYTES) : 11'(xmr_pkg::SHORT_BLOCK_BYTES);
    acc_sum = {1'b0, acc_q} + (COUNT_BITS+1)'(nlen);
    good = 1'b0; chk_ok = 1'b0; at_end = 1'b0; crc_eff = crc_mode_q;
    nr = {1'b0, retry_q} + 7'd1;
    if (take_i) begin
      case (func_i)
        xmr_pkg::FUNC_START: begin
          exp_d = 8'd1; retry_d = '0; idx_d = '0; long_d = 1'b0; blk_d = '0;
          cmp_d = '0; crc_d = '0; sum_d = '0; chk_d = '0; acc_d = '0;
          phase_d = xmr_pkg::PH_POLL;
          crc_eff = (fallback_poll_i != 8'd0);
          crc_mode_d = crc_eff;
          poll_d = 8'd1;
          c.act = xmr_pkg::ACT_SINGLE; c.tx_valid = 1'b1;
          c.tx_byte = crc_eff ? xmr_pkg::B_POLL : xmr_pkg::B_NAK;
        end
        xmr_pkg::FUNC_TICK: begin
          if (phase_q == xmr_pkg::PH_POLL) begin
            if (poll_q >= poll_limit_i) begin
              c.act = xmr_pkg::ACT_CAN3; c.status = xmr_pkg::STAT_ERROR;
              phase_d = xmr_pkg::PH_IDLE;
            end else begin
              if (poll_q >= fallback_poll_i) crc_eff = 1'b0;
              crc_mode_d = crc_eff;
              if (poll_q != 8'hFF) poll_d = poll_q + 8'd1;
              c.act = xmr_pkg::ACT_SINGLE; c.tx_valid = 1'b1;
              c.tx_byte = crc_eff ? xmr_pkg::B_POLL : xmr_pkg::B_NAK;
            end
          end else if (phase_q == xmr_pkg::PH_FRAME || phase_q == xmr_pkg::PH_NEXT) begin
            c.act = xmr_pkg::ACT_CAN3; c.status = xmr_pkg::STAT_ERROR;
            phase_d = xmr_pkg::PH_IDLE;
          end
        end
        xmr_pkg::FUNC_BYTE: begin
          if (phase_q == xmr_pkg::PH_POLL || phase_q == xmr_pkg::PH_NEXT) begin
            if (rx_byte_i == xmr_pkg::B_SOH || rx_byte_i == xmr_pkg::B_STX) begin
              long_d = (rx_byte_i == xmr_pkg::B_STX);
              idx_d = '0; crc_d = '0; sum_d = '0; chk_d = '0;
              phase_d = xmr_pkg::PH_FRAME;
            end else if (rx_byte_i == xmr_pkg::B_EOT) begin
              c.act = xmr_pkg::ACT_ACK2; c.status = xmr_pkg::STAT_DONE;
              phase_d = xmr_pkg::PH_IDLE;
            end else if (rx_byte_i == xmr_pkg::B_CAN) begin
              c.act = xmr_pkg::ACT_SILENT; c.status = xmr_pkg::STAT_CANCEL;
              phase_d = xmr_pkg::PH_IDLE;
            end else begin
              c.act = xmr_pkg::ACT_CAN3; c.status = xmr_pkg::STAT_ERROR;
              phase_d = xmr_pkg::PH_IDLE;
            end
          end else if (phase_q == xmr_pkg::PH_FRAME) begin
            idx_d = idx_q + 11'd1;
            if (idx_q == 11'd0) blk_d = rx_byte_i;
            else if (idx_q == 11'd1) cmp_d = rx_byte_i;
            else if (idx_q < nlen + 11'd2) begin
              crc_d = xmr_pkg::crc_byte(crc_q, rx_byte_i);
              sum_d = sum_q + rx_byte_i;
              c.act = xmr_pkg::ACT_SINGLE; c.payload_valid = 1'b1;
              c.payload_byte = rx_byte_i;
            end else if (crc_mode_q) begin
              if (idx_q == nlen + 11'd2) chk_d = rx_byte_i;
              else begin
                at_end = 1'b1; chk_ok = ({chk_q, rx_byte_i} == crc_q);
              end
            end else begin
              at_end = 1'b1; chk_ok = (rx_byte_i == sum_q);
            end
            if (at_end) begin
              good = chk_ok && ((blk_q ^ cmp_q) == 8'hFF);
              if (good && blk_q == exp_q) begin
                acc_d = acc_sum[COUNT_BITS] ? CMAX : acc_sum[COUNT_BITS-1:0];
                exp_d = exp_q + 8'd1; retry_d = '0;
                c.act = xmr_pkg::ACT_SINGLE; c.tx_valid = 1'b1;
                c.tx_byte = xmr_pkg::B_ACK; c.verdict = xmr_pkg::VERD_ACCEPT;
                phase_d = xmr_pkg::PH_NEXT;
                c.status = (32'(acc_d) >= 32'(capacity_i))
                           ? xmr_pkg::STAT_CAP : xmr_pkg::STAT_ACTIVE;
              end else if (good && blk_q == exp_q - 8'd1) begin
                retry_d = '0;
                c.act = xmr_pkg::ACT_SINGLE; c.tx_valid = 1'b1;
                c.tx_byte = xmr_pkg::B_ACK; c.verdict = xmr_pkg::VERD_DUP;
                phase_d = xmr_pkg::PH_NEXT;
              end else if (nr <= {1'b0, retry_limit_i}) begin
                retry_d = nr[5:0];
                c.act = xmr_pkg::ACT_SINGLE; c.tx_valid = 1'b1;
                c.tx_byte = xmr_pkg::B_NAK; c.verdict = xmr_pkg::VERD_RETRY;
                phase_d = xmr_pkg::PH_NEXT;
              end else begin
                retry_d = '0;
                c.act = xmr_pkg::ACT_CAN3; c.verdict = xmr_pkg::VERD_ABORT;
                c.status = xmr_pkg::STAT_ERROR;
                phase_d = xmr_pkg::PH_IDLE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    c.count = 24'(acc_d);
  end

  assign cmd_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xmr_pkg::PH_IDLE; crc_mode_q <= 1'b1; poll_q <= '0; exp_q <= 8'd1;
      retry_q <= '0; idx_q <= '0; long_q <= 1'b0; blk_q <= '0; cmp_q <= '0;
      crc_q <= '0; sum_q <= '0; chk_q <= '0; acc_q <= '0;
    end else begin
      phase_q <= phase_d; crc_mode_q <= crc_mode_d; poll_q <= poll_d; exp_q <= exp_d;
      retry_q <= retry_d; idx_q <= idx_d; long_q <= long_d; blk_q <= blk_d;
      cmp_q <= cmp_d; crc_q <= crc_d; sum_q <= sum_d; chk_q <= chk_d; acc_q <= acc_d;
    end
  end

endmodule

FILE: rtl/xmr_queue.sv
module xmr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xmr_pkg::cmd_t data_i,
  input  logic          pop_i,
  output xmr_pkg::cmd_t data_o,
  output logic          empty_o,
  output logic          full_o
);

  xmr_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign data_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

FILE: rtl/xmr_back.sv
module xmr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  xmr_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output xmr_pkg::res_t res_o,
  input  logic          res_ready_i
);

  logic [1:0] step_q, step_d;
  logic [1:0] total;
  logic       out_v_q;
  xmr_pkg::res_t out_q;
  xmr_pkg::res_t r;
  logic       load;

  always_comb begin
    case (cmd_i.act)
      xmr_pkg::ACT_ACK2: total = 2'd2;
      xmr_pkg::ACT_CAN3: total = 2'd3;
      default:           total = 2'd1;
    endcase
    r.tx_valid = cmd_i.tx_valid;
    r.tx_byte = cmd_i.tx_byte;
    r.payload_valid = cmd_i.payload_valid;
    r.payload_byte = cmd_i.payload_byte;
    r.frame_verdict = (step_q == 2'd0) ? cmd_i.verdict : xmr_pkg::VERD_NONE;
    r.session_status = cmd_i.status;
    r.delivered_count = cmd_i.count;
    r.last = (step_q + 2'd1 == total);
    case (cmd_i.act)
      xmr_pkg::ACT_ACK2: begin r.tx_valid = 1'b1; r.tx_byte = xmr_pkg::B_ACK; end
      xmr_pkg::ACT_CAN3: begin r.tx_valid = 1'b1; r.tx_byte = xmr_pkg::B_CAN; end
      xmr_pkg::ACT_SILENT: begin r.tx_valid = 1'b0; r.tx_byte = '0; end
      default: begin
      end
    endcase
    load = cmd_valid_i && (!out_v_q || res_ready_i);
    step_d = step_q;
    cmd_pop_o = 1'b0;
    if (load) begin
      if (r.last) begin
        step_d = '0; cmd_pop_o = 1'b1;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0; out_v_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) out_v_q <= 1'b1;
      else if (res_ready_i) out_v_q <= 1'b0;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o = out_q;

endmodule

FILE: rtl/xmodem_block_receiver.sv
// The first result of a request goes through the command queue and the output register
// and is held back while earlier results still wait; ACK and CAN bursts come from one
// queued command. Throughput: one request per cycle while the queue is not full; a
// request with two or three results holds the output side until its last is loaded, and
// a two-entry command queue between the front and back ends absorbs that. Reset clears
// session state to idle and the registers to their defaults at once; no clearing pass.
module xmodem_block_receiver #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  xmr_in_if.sink    in_if,
  xmr_cfg_if.sink   cfg_if,
  xmr_out_if.source out_if
);

  `include "xmodem_block_receiver_macros.svh"

  logic [5:0]  retry_q;
  logic [7:0]  poll_q, fb_q;
  logic [23:0] cap_q;
  xmr_pkg::cmd_t cmd, qcmd;
  xmr_pkg::res_t res;
  logic take, push, pop, empty, full;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= 6'd32; poll_q <= 8'd60; fb_q <= 8'd30; cap_q <= 24'd1024;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        xmr_pkg::REG_RETRY:    retry_q <= cfg_if.data[5:0];
        xmr_pkg::REG_POLL:     poll_q <= cfg_if.data[7:0];
        xmr_pkg::REG_FALLBACK: fb_q <= cfg_if.data[7:0];
        xmr_pkg::REG_CAPACITY: cap_q <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = !full;
  assign take = in_if.valid && in_if.ready;

  xmr_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i, .rst_ni, .take_i(take), .func_i(in_if.func), .rx_byte_i(in_if.rx_byte),
    .retry_limit_i(retry_q), .poll_limit_i(poll_q), .fallback_poll_i(fb_q),
    .capacity_i(cap_q), .cmd_o(cmd)
  );

  assign push = take && (cmd.act != xmr_pkg::ACT_NONE);

  xmr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd), .pop_i(pop),
    .data_o(qcmd), .empty_o(empty), .full_o(full)
  );

  xmr_back u_back (
    .clk_i, .rst_ni, .cmd_i(qcmd), .cmd_valid_i(!empty), .cmd_pop_o(pop),
    .res_valid_o(out_if.valid), .res_o(res), .res_ready_i(out_if.ready)
  );

  assign out_if.tx_valid = res.tx_valid;
  assign out_if.tx_byte = res.tx_byte;
  assign out_if.payload_valid = res.payload_valid;
  assign out_if.payload_byte = res.payload_byte;
  assign out_if.frame_verdict = res.frame_verdict;
  assign out_if.session_status = res.session_status;
  assign out_if.delivered_count = res.delivered_count;
  assign out_if.last = res.last;

  `XMR_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, full, !push, "queue overflow")
  `XMR_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, !empty, "pop of empty queue")
  `XMR_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready,
                   out_if.valid, "result dropped while stalled")

endmodule

FILE: tb/testbench.sv
module testbench;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [23:0] CAP_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {S_IDLE, S_POLL, S_FRAME, S_NEXT} rx_phase_e;

  logic clk;
  logic rst_n;

  xmr_in_if  in_ch();
  xmr_out_if out_ch();
  xmr_cfg_if cfg_ch();

  xmodem_block_receiver u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_if (in_ch),
    .cfg_if(cfg_ch),
    .out_if(out_ch)
  );

  // Register copies and session state of the predictor.
  logic [5:0]  lim_retry;
  logic [7:0]  lim_poll;
  logic [7:0]  poll_fallback;
  logic [23:0] cap_bytes;
  rx_phase_e   ph;
  logic        use_crc;
  logic [7:0]  polls;
  logic [7:0]  want_blk;
  logic [5:0]  retries;
  logic [10:0] idx;
  logic        is_long;
  logic [7:0]  rx_blk;
  logic [7:0]  rx_cmp;
  logic [15:0] fcs;
  logic [7:0]  sum8;
  logic [7:0]  fcs_hi;
  logic [23:0] delivered;

  xmr_pkg::res_t pend[3];
  int   pend_n;
  xmr_pkg::res_t exp_results[$];

  int mismatches;
  int failures;
  int accepted_items;
  int results_seen;
  int frames_sent;
  int burst_left;
  bit no_gaps;
  int stall_mode;
  int hold_req;
  int hold_left;
  int stall_cyc;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [15:0] fcs16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic void emit(logic txv, logic [7:0] txb, logic pv, logic [7:0] pb,
                               logic [2:0] verd);
    xmr_pkg::res_t r;
    if (pend_n >= 3) return;
    r = '0;
    r.tx_valid = txv;
    r.tx_byte = txb;
    r.payload_valid = pv;
    r.payload_byte = pb;
    r.frame_verdict = verd;
    pend[pend_n] = r;
    pend_n++;
  endfunction

  function automatic void cancel_burst(logic [2:0] verd);
    emit(1'b1, xmr_pkg::B_CAN, 1'b0, 8'h00, verd);
    emit(1'b1, xmr_pkg::B_CAN, 1'b0, 8'h00, xmr_pkg::VERD_NONE);
    emit(1'b1, xmr_pkg::B_CAN, 1'b0, 8'h00, xmr_pkg::VERD_NONE);
    ph = S_IDLE;
  endfunction

  function automatic void poll_sender();
    if (polls >= poll_fallback) use_crc = 1'b0;
    emit(1'b1, use_crc ? xmr_pkg::B_POLL : xmr_pkg::B_NAK, 1'b0, 8'h00,
         xmr_pkg::VERD_NONE);
    if (polls != 8'hFF) polls++;
  endfunction

  function automatic logic [2:0] take_header(logic [7:0] b);
    if (b == xmr_pkg::B_SOH || b == xmr_pkg::B_STX) begin
      is_long = (b == xmr_pkg::B_STX);
      idx = '0;
      fcs = '0;
      sum8 = '0;
      fcs_hi = '0;
      ph = S_FRAME;
      return xmr_pkg::STAT_ACTIVE;
    end
    if (b == xmr_pkg::B_EOT) begin
      emit(1'b1, xmr_pkg::B_ACK, 1'b0, 8'h00, xmr_pkg::VERD_NONE);
      emit(1'b1, xmr_pkg::B_ACK, 1'b0, 8'h00, xmr_pkg::VERD_NONE);
      ph = S_IDLE;
      return xmr_pkg::STAT_DONE;
    end
    if (b == xmr_pkg::B_CAN) begin
      emit(1'b0, 8'h00, 1'b0, 8'h00, xmr_pkg::VERD_NONE);
      ph = S_IDLE;
      return xmr_pkg::STAT_CANCEL;
    end
    cancel_burst(xmr_pkg::VERD_NONE);
    return xmr_pkg::STAT_ERROR;
  endfunction

  function automatic logic [2:0] judge_frame(logic chk_ok);
    logic good;
    logic [24:0] sum;
    good = chk_ok && ((rx_blk ^ rx_cmp) == 8'hFF);
    if (good && rx_blk == want_blk) begin
      sum = {1'b0, delivered} + (is_long ? 25'(xmr_pkg::LONG_BLOCK_BYTES)
                                         : 25'(xmr_pkg::SHORT_BLOCK_BYTES));
      delivered = sum[24] ? CAP_MAX : sum[23:0];
      want_blk++;
      retries = '0;
      emit(1'b1, xmr_pkg::B_ACK, 1'b0, 8'h00, xmr_pkg::VERD_ACCEPT);
      ph = S_NEXT;
      return (delivered >= cap_bytes) ? xmr_pkg::STAT_CAP : xmr_pkg::STAT_ACTIVE;
    end
    if (good && rx_blk == want_blk - 8'd1) begin
      retries = '0;
      emit(1'b1, xmr_pkg::B_ACK, 1'b0, 8'h00, xmr_pkg::VERD_DUP);
      ph = S_NEXT;
      return xmr_pkg::STAT_ACTIVE;
    end
    if ({1'b0, retries} + 7'd1 <= {1'b0, lim_retry}) begin
      retries++;
      emit(1'b1, xmr_pkg::B_NAK, 1'b0, 8'h00, xmr_pkg::VERD_RETRY);
      ph = S_NEXT;
      return xmr_pkg::STAT_ACTIVE;
    end
    retries = '0;
    cancel_burst(xmr_pkg::VERD_ABORT);
    return xmr_pkg::STAT_ERROR;
  endfunction

  function automatic logic [2:0] take_frame_byte(logic [7:0] b);
    int unsigned n;
    int unsigned i;
    n = is_long ? xmr_pkg::LONG_BLOCK_BYTES : xmr_pkg::SHORT_BLOCK_BYTES;
    i = idx;
    idx++;
    if (i == 0) begin
      rx_blk = b;
      return xmr_pkg::STAT_ACTIVE;
    end
    if (i == 1) begin
      rx_cmp = b;
      return xmr_pkg::STAT_ACTIVE;
    end
    if (i < n + 2) begin
      fcs = fcs16_step(fcs, b);
      sum8 += b;
      emit(1'b0, 8'h00, 1'b1, b, xmr_pkg::VERD_NONE);
      return xmr_pkg::STAT_ACTIVE;
    end
    if (use_crc) begin
      if (i == n + 2) begin
        fcs_hi = b;
        return xmr_pkg::STAT_ACTIVE;
      end
      return judge_frame({fcs_hi, b} == fcs);
    end
    return judge_frame(b == sum8);
  endfunction

  // Works out the results of one accepted request and queues them.
  function automatic void predict_item(logic [1:0] f, logic [7:0] b);
    logic [2:0] st;
    pend_n = 0;
    st = xmr_pkg::STAT_ACTIVE;
    if (f == xmr_pkg::FUNC_START) begin
      use_crc = 1'b1; polls = '0; want_blk = 8'd1; retries = '0; idx = '0;
      is_long = 1'b0; rx_blk = '0; rx_cmp = '0; fcs = '0; sum8 = '0; fcs_hi = '0;
      delivered = '0;
      ph = S_POLL;
      poll_sender();
    end else if (f == xmr_pkg::FUNC_TICK) begin
      if (ph == S_POLL) begin
        if (polls >= lim_poll) begin
          cancel_burst(xmr_pkg::VERD_NONE);
          st = xmr_pkg::STAT_ERROR;
        end else begin
          poll_sender();
        end
      end else if (ph == S_FRAME || ph == S_NEXT) begin
        cancel_burst(xmr_pkg::VERD_NONE);
        st = xmr_pkg::STAT_ERROR;
      end
    end else if (f == xmr_pkg::FUNC_BYTE) begin
      if (ph == S_POLL || ph == S_NEXT) st = take_header(b);
      else if (ph == S_FRAME) st = take_frame_byte(b);
    end
    for (int k = 0; k < pend_n; k++) begin
      pend[k].session_status = st;
      pend[k].delivered_count = delivered;
      pend[k].last = (k == pend_n - 1);
      exp_results.push_back(pend[k]);
    end
  endfunction

  task automatic send_item(logic [1:0] f, logic [7:0] b);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(f, b);
    accepted_items++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] r, logic [23:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (r)
      xmr_pkg::REG_RETRY:    lim_retry = d[5:0];
      xmr_pkg::REG_POLL:     lim_poll = d[7:0];
      xmr_pkg::REG_FALLBACK: poll_fallback = d[7:0];
      default:               cap_bytes = d;
    endcase
    @(posedge clk);
  endtask

  // Sends one frame. A negative cut, or one past the data, sends it whole;
  // otherwise a tick follows after max(cut, 2) bytes behind the header.
  task automatic send_frame(bit lng, logic [7:0] blk, logic [7:0] cmp, bit bad_chk,
                            int cut, bit edge_data);
    int unsigned n;
    logic [15:0] c;
    logic [7:0] s;
    logic [7:0] d;
    n = lng ? xmr_pkg::LONG_BLOCK_BYTES : xmr_pkg::SHORT_BLOCK_BYTES;
    c = '0;
    s = '0;
    frames_sent++;
    send_item(xmr_pkg::FUNC_BYTE, lng ? xmr_pkg::B_STX : xmr_pkg::B_SOH);
    send_item(xmr_pkg::FUNC_BYTE, blk);
    send_item(xmr_pkg::FUNC_BYTE, cmp);
    for (int unsigned i = 0; i < n; i++) begin
      if (cut >= 0 && i + 2 >= cut) begin
        send_item(xmr_pkg::FUNC_TICK, 8'($urandom()));
        return;
      end
      d = edge_data ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom());
      c = fcs16_step(c, d);
      s += d;
      send_item(xmr_pkg::FUNC_BYTE, d);
    end
    if (bad_chk) begin
      c ^= 16'h0001;
      s ^= 8'h80;
    end
    if (use_crc) begin
      send_item(xmr_pkg::FUNC_BYTE, c[15:8]);
      send_item(xmr_pkg::FUNC_BYTE, c[7:0]);
    end else begin
      send_item(xmr_pkg::FUNC_BYTE, s);
    end
  endtask

  task automatic good_frame(bit lng);
    send_frame(lng, want_blk, ~want_blk, 1'b0, -1, 1'b0);
  endtask

  // Receiver: checks each accepted result; the block below decides the next ready.
  always @(posedge clk) begin
    xmr_pkg::res_t got;
    xmr_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.tx_valid = out_ch.tx_valid;
      got.tx_byte = out_ch.tx_byte;
      got.payload_valid = out_ch.payload_valid;
      got.payload_byte = out_ch.payload_byte;
      got.frame_verdict = out_ch.frame_verdict;
      got.session_status = out_ch.session_status;
      got.delivered_count = out_ch.delivered_count;
      got.last = out_ch.last;
      results_seen++;
      if (exp_results.size() == 0) begin
        mismatches++;
        failures++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = exp_results.pop_front();
        if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
            got.payload_valid !== want.payload_valid ||
            got.payload_byte !== want.payload_byte ||
            got.frame_verdict !== want.frame_verdict ||
            got.session_status !== want.session_status ||
            got.delivered_count !== want.delivered_count || got.last !== want.last) begin
          mismatches++;
          failures++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    stall_cyc++;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) hold_left--;
    case (stall_mode)
      0:       out_ch.ready <= (hold_left == 0);
      1:       out_ch.ready <= (hold_left == 0) && ($urandom_range(3) != 0);
      default: out_ch.ready <= (hold_left == 0) && (stall_cyc % 5 != 2);
    endcase
  end

  task automatic test_directed();
    send_item(xmr_pkg::FUNC_BYTE, 8'hFF);   // idle: ignored
    send_item(xmr_pkg::FUNC_TICK, 8'h00);
    send_item(FUNC_UNUSED, 8'hA5);
    send_item(xmr_pkg::FUNC_START, 8'h00);
    send_item(xmr_pkg::FUNC_TICK, 8'h00);
    send_item(xmr_pkg::FUNC_BYTE, xmr_pkg::B_CAN);   // sender cancels
    send_item(xmr_pkg::FUNC_START, 8'h00);
    send_item(xmr_pkg::FUNC_BYTE, 8'h7E);   // unknown header
    send_item(xmr_pkg::FUNC_START, 8'h00);
    send_frame(1'b0, 8'd1, 8'hFE, 1'b0, -1, 1'b1);
    send_frame(1'b0, 8'd1, 8'hFE, 1'b0, -1, 1'b0);   // duplicate
    send_frame(1'b0, 8'd2, 8'h00, 1'b0, -1, 1'b0);   // bad complement
    send_frame(1'b0, 8'd2, 8'hFD, 1'b1, -1, 1'b0);   // bad check
    send_frame(1'b1, 8'd2, 8'hFD, 1'b0, -1, 1'b0);
    send_item(xmr_pkg::FUNC_START, 8'h00);  // restart mid-session
    send_frame(1'b0, 8'd1, 8'hFE, 1'b0, 20, 1'b0);   // frame timeout
    send_item(xmr_pkg::FUNC_START, 8'h00);
    good_frame(1'b0);
    send_item(xmr_pkg::FUNC_TICK, 8'h00);   // timeout awaiting the next header
    send_item(xmr_pkg::FUNC_START, 8'h00);
    good_frame(1'b0);
    send_item(xmr_pkg::FUNC_BYTE, xmr_pkg::B_EOT);
    wait_drain();
  endtask

  task automatic test_registers();
    write_reg(xmr_pkg::REG_POLL, 24'd1);
    send_item(xmr_pkg::FUNC_START, 8'h00);
    send_item(xmr_pkg::FUNC_TICK, 8'h00);   // poll limit passed
    wait_drain();
    write_reg(xmr_pkg::REG_POLL, 24'd255);
    write_reg(xmr_pkg::REG_FALLBACK, 24'd2);
    send_item(xmr_pkg::FUNC_START, 8'h00);
    repeat (3) send_item(xmr_pkg::FUNC_TICK, 8'h00);
    good_frame(1'b0);              // sum mode
    send_frame(1'b0, want_blk, ~want_blk, 1'b1, -1, 1'b0);
    good_frame(1'b0);
    wait_drain();
    write_reg(xmr_pkg::REG_RETRY, 24'd0);
    write_reg(xmr_pkg::REG_CAPACITY, 24'd1);
    write_reg(xmr_pkg::REG_FALLBACK, 24'd0);
    send_item(xmr_pkg::FUNC_START, 8'h00);
    good_frame(1'b0);
    send_frame(1'b0, 8'd9, 8'hF6, 1'b0, -1, 1'b0);   // aborts at once
    wait_drain();
    write_reg(xmr_pkg::REG_RETRY, 24'd63);
    write_reg(xmr_pkg::REG_CAPACITY, CAP_MAX);
    write_reg(xmr_pkg::REG_FALLBACK, 24'd255);
    send_item(xmr_pkg::FUNC_START, 8'h00);
    good_frame(1'b0);
    wait_drain();
    write_reg(xmr_pkg::REG_RETRY, 24'd2);
    write_reg(xmr_pkg::REG_POLL, 24'd6);
    write_reg(xmr_pkg::REG_FALLBACK, 24'd3);
    write_reg(xmr_pkg::REG_CAPACITY, 24'd256);
  endtask

  task automatic test_random();
    int start_items;
    int pick;
    start_items = accepted_items;
    while (accepted_items - start_items < 300) begin
      send_item(xmr_pkg::FUNC_START, 8'h00);
      repeat ($urandom_range(0, 8)) send_item(xmr_pkg::FUNC_TICK, 8'($urandom()));
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 11) good_frame(1'b0);
        else if (pick == 11) good_frame(1'b1);
        else if (pick == 12) send_frame(1'b0, want_blk - 8'd1, ~(want_blk - 8'd1), 1'b0, -1,
                                        1'b0);
        else if (pick == 13) send_frame(1'b0, want_blk, ~want_blk, 1'b1, -1, 1'b0);
        else if (pick == 14) send_frame(1'b0, 8'($urandom()), 8'($urandom()), 1'b0, -1,
                                        1'b0);
        else if (pick == 15) send_frame(1'b0, want_blk, ~want_blk, 1'b0,
                                        $urandom_range(0, 131), 1'b0);
        else if (pick == 16) send_item(xmr_pkg::FUNC_BYTE, 8'($urandom()));
        else if (pick == 17) send_item(FUNC_UNUSED, 8'($urandom()));
        else send_item(xmr_pkg::FUNC_TICK, 8'($urandom()));
      end
      if ($urandom_range(1) != 0) send_item(xmr_pkg::FUNC_BYTE, xmr_pkg::B_EOT);
      if ($urandom_range(5) == 0) begin
        wait_drain();
        write_reg(xmr_pkg::REG_RETRY, 24'($urandom_range(0, 63)));
        write_reg(xmr_pkg::REG_POLL, 24'($urandom_range(1, 255)));
        write_reg(xmr_pkg::REG_FALLBACK, 24'($urandom_range(0, 255)));
        write_reg(xmr_pkg::REG_CAPACITY, 24'($urandom_range(1, 2048)));
        stall_mode = $urandom_range(0, 2);
        no_gaps = $urandom_range(3) == 0;
      end
    end
  endtask

  task automatic test_pressure();
    no_gaps = 1'b1;
    hold_req = 300;
    send_item(xmr_pkg::FUNC_START, 8'h00);
    good_frame(1'b0);
    repeat (40) send_item(xmr_pkg::FUNC_TICK, 8'h00);
    // Pause the sender until everything is out.
    wait_drain();
    no_gaps = 1'b0;
    send_item(xmr_pkg::FUNC_START, 8'h00);
    good_frame(1'b0);
    wait_drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= xmr_pkg::FUNC_BYTE;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= xmr_pkg::REG_RETRY;
    cfg_ch.data <= '0;
    lim_retry = 6'd32; lim_poll = 8'd60; poll_fallback = 8'd30; cap_bytes = 24'd1024;
    ph = S_IDLE; use_crc = 1'b1; polls = '0; want_blk = 8'd1; retries = '0; idx = '0;
    is_long = 1'b0; rx_blk = '0; rx_cmp = '0; fcs = '0; sum8 = '0; fcs_hi = '0;
    delivered = '0;
    mismatches = 0; failures = 0; accepted_items = 0; results_seen = 0; frames_sent = 0;
    burst_left = 0; no_gaps = 1'b0; stall_mode = 1; hold_req = 0; hold_left = 0;
    stall_cyc = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_registers();
    test_pressure();
    test_random();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests, %0d frames and %0d responses checked,",
             accepted_items, frames_sent, results_seen);
    $display("with polling, fallback, retries, duplicates, aborts and back-pressure.");
    if (failures == 0 && exp_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d failures, %0d mismatches", failures, mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: xmodem_block_receiver.f
+incdir+rtl
rtl/xmr_pkg.sv
rtl/xmr_if.sv
rtl/xmr_front.sv
rtl/xmr_queue.sv
rtl/xmr_back.sv
rtl/xmodem_block_receiver.sv
tb/testbench.sv
